// File: rtl/core/i2cms_pkg.sv
// Shared types and codes for the I2C master transfer sequencer.
`default_nettype none

package i2cms_pkg;

    // Command codes carried with each input item
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EVENT = 2'd2
    } cmd_e;

    // Transfer kinds
    typedef enum logic [1:0] {
        XK_WRITE     = 2'd0,
        XK_READ      = 2'd1,
        XK_REG_WRITE = 2'd2,
        XK_REG_READ  = 2'd3
    } xfer_kind_e;

    // Abstracted bus-controller events
    typedef enum logic [2:0] {
        EV_START_SENT  = 3'd0,
        EV_TX_SELECTED = 3'd1,
        EV_TX_BUSY     = 3'd2,
        EV_TX_DONE     = 3'd3,
        EV_RX_SELECTED = 3'd4,
        EV_RX_DONE     = 3'd5,
        EV_OTHER       = 3'd6
    } event_e;

    // Kind of byte carried by a result item
    typedef enum logic [1:0] {
        BK_NONE = 2'd0,
        BK_ADDR = 2'd1,
        BK_DATA = 2'd2,
        BK_RECV = 2'd3
    } byte_kind_e;

    // Interrupt disable codes
    typedef enum logic [1:0] {
        IRQ_NONE  = 2'd0,
        IRQ_BUF   = 2'd1,
        IRQ_EVENT = 2'd2,
        IRQ_BOTH  = 2'd3
    } irq_e;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_RECOVERED = 2'd3
    } status_e;

    // One input item
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  tx_byte;
        logic [1:0]  transfer_type;
        logic [6:0]  slave_address;
        logic [15:0] register_address;
        logic        register_wide;
        logic [7:0]  length;
        logic        bus_busy;
        logic [2:0]  event_code;
        logic [7:0]  rx_data;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [1:0] byte_kind;
        logic [7:0] out_byte;
        logic [7:0] rx_position;
        logic       gen_start;
        logic       gen_stop;
        logic       ack_disable;
        logic [1:0] irq_off;
        logic       complete;
        logic [1:0] status;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cms_store.sv
// Payload byte store with registered, prefetching read port.
`default_nettype none

module i2cms_store #(
    parameter int unsigned TX_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(TX_DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(TX_DEPTH)-1:0] rd_addr,
    output logic      [7:0]                  rd_data
);

    logic [7:0] mem [TX_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port, and a read that forwards a same-cycle write to the same entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/i2cms_core.sv
// Transfer state and per-item decision logic of the sequencer.
`default_nettype none

module i2cms_core #(
    parameter int unsigned TX_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire i2cms_pkg::in_item_t         item,
    input  wire logic [7:0]                  rd_data,
    output i2cms_pkg::out_item_t             result,
    output logic                             wr_en,
    output logic      [$clog2(TX_DEPTH)-1:0] wr_addr,
    output logic      [7:0]                  wr_data,
    output logic                             rd_en,
    output logic      [$clog2(TX_DEPTH)-1:0] rd_addr
);

    localparam int unsigned CNT_W = $clog2(TX_DEPTH + 2);
    localparam int unsigned SP_W  = $clog2(TX_DEPTH + 3);
    localparam int unsigned IDX_W = $clog2(TX_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TX_DEPTH);
    localparam logic [CNT_W-1:0] OVER_C  = CNT_W'(TX_DEPTH + 1);
    localparam logic [SP_W-1:0]  DEPTH_S = SP_W'(TX_DEPTH);

    logic [1:0]       kind_reg,   kind_next;
    logic [6:0]       target_reg, target_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [15:0]      prefix_reg, prefix_next;
    logic [1:0]       pcnt_reg,   pcnt_next;
    logic [SP_W-1:0]  sp_reg,     sp_next;
    logic [7:0]       rlen_reg,   rlen_next;
    logic [7:0]       rpos_reg,   rpos_next;
    logic             done_reg,   done_next;

    logic [CNT_W-1:0] stored;
    logic [SP_W-1:0]  total;
    logic [SP_W-1:0]  sp_inc;
    logic [7:0]       pbyte;
    logic [7:0]       rpos_inc;
    logic             rx_last_sel;
    logic             rx_last_after;
    logic             rx_end_after;
    logic             rx_more;
    logic [SP_W-1:0]  rd_full;
    logic             is_write_kind;

    // Helper terms from the current state
    assign stored        = (cnt_reg > DEPTH_C) ? DEPTH_C : cnt_reg;
    assign total         = SP_W'(pcnt_reg) + SP_W'(stored);
    assign sp_inc        = sp_reg + SP_W'(1);
    assign pbyte         = ((pcnt_reg == 2'd2) && (sp_reg == '0)) ? prefix_reg[15:8]
                                                                  : prefix_reg[7:0];
    assign rpos_inc      = rpos_reg + 8'd1;
    assign rx_last_sel   = (({1'b0, rlen_reg} - {1'b0, rpos_reg}) == 9'd1);
    assign rx_last_after = (({1'b0, rlen_reg} - {1'b0, rpos_inc}) == 9'd1);
    assign rx_end_after  = (rlen_reg == rpos_inc);
    assign rx_more       = (rpos_reg < rlen_reg);
    assign is_write_kind = (item.transfer_type == i2cms_pkg::XK_WRITE)
                        || (item.transfer_type == i2cms_pkg::XK_REG_WRITE);

    // Next state and result for the item in hand
    always_comb
    begin
        logic rx_path;
        logic err;
        rx_path     = 1'b0;
        err         = 1'b0;
        kind_next   = kind_reg;
        target_next = target_reg;
        cnt_next    = cnt_reg;
        prefix_next = prefix_reg;
        pcnt_next   = pcnt_reg;
        sp_next     = sp_reg;
        rlen_next   = rlen_reg;
        rpos_next   = rpos_reg;
        done_next   = done_reg;
        result      = '0;

        unique case (i2cms_pkg::cmd_e'(item.command))
            i2cms_pkg::CMD_LOAD:
            begin
                if (cnt_reg < DEPTH_C)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_next = OVER_C;
                end
            end
            i2cms_pkg::CMD_START:
            begin
                if (item.bus_busy)
                begin
                    result.status = i2cms_pkg::ST_BUSY;
                end
                else if (is_write_kind && (cnt_reg > DEPTH_C))
                begin
                    result.status = i2cms_pkg::ST_TOO_LONG;
                    cnt_next      = '0;
                end
                else
                begin
                    kind_next   = item.transfer_type;
                    target_next = item.slave_address;
                    prefix_next = item.register_address;
                    pcnt_next   = item.transfer_type[1] ? (item.register_wide ? 2'd2 : 2'd1)
                                                        : 2'd0;
                    rlen_next   = (item.length == 8'd0) ? 8'd1 : item.length;
                    sp_next     = '0;
                    rpos_next   = '0;
                    done_next   = 1'b0;
                    result.gen_start = 1'b1;
                end
            end
            i2cms_pkg::CMD_EVENT:
            begin
                if (!done_reg)
                begin
                    unique case (i2cms_pkg::xfer_kind_e'(kind_reg)) inside
                        i2cms_pkg::XK_WRITE, i2cms_pkg::XK_REG_WRITE:
                        begin
                            case (item.event_code) inside
                                i2cms_pkg::EV_START_SENT:
                                begin
                                    result.byte_kind = i2cms_pkg::BK_ADDR;
                                    result.out_byte  = {target_reg, 1'b0};
                                end
                                i2cms_pkg::EV_TX_SELECTED, i2cms_pkg::EV_TX_BUSY:
                                begin
                                    if (sp_reg < total)
                                    begin
                                        result.byte_kind = i2cms_pkg::BK_DATA;
                                        result.out_byte  = (sp_reg < SP_W'(pcnt_reg)) ? pbyte
                                                                                      : rd_data;
                                        sp_next = sp_inc;
                                    end
                                    else
                                    begin
                                        result.irq_off = i2cms_pkg::IRQ_BUF;
                                    end
                                end
                                i2cms_pkg::EV_TX_DONE:
                                begin
                                    result.gen_stop = 1'b1;
                                    result.irq_off  = i2cms_pkg::IRQ_EVENT;
                                    done_next       = 1'b1;
                                    cnt_next        = '0;
                                end
                                default:
                                begin
                                    err = 1'b1;
                                end
                            endcase
                        end
                        i2cms_pkg::XK_READ:
                        begin
                            if (item.event_code == i2cms_pkg::EV_START_SENT)
                            begin
                                result.byte_kind = i2cms_pkg::BK_ADDR;
                                result.out_byte  = {target_reg, 1'b1};
                            end
                            else
                            begin
                                rx_path = 1'b1;
                            end
                        end
                        default:
                        begin
                            // register read: prefix out, restart, then receive
                            case (item.event_code) inside
                                i2cms_pkg::EV_START_SENT:
                                begin
                                    result.byte_kind = i2cms_pkg::BK_ADDR;
                                    result.out_byte  = {target_reg, (sp_reg != '0)};
                                end
                                i2cms_pkg::EV_TX_SELECTED, i2cms_pkg::EV_TX_BUSY:
                                begin
                                    if (sp_reg < SP_W'(pcnt_reg))
                                    begin
                                        result.byte_kind = i2cms_pkg::BK_DATA;
                                        result.out_byte  = pbyte;
                                        sp_next          = sp_inc;
                                    end
                                end
                                i2cms_pkg::EV_TX_DONE:
                                begin
                                    result.gen_start = 1'b1;
                                end
                                default:
                                begin
                                    rx_path = 1'b1;
                                end
                            endcase
                        end
                    endcase

                    // Receive side shared by both read kinds
                    if (rx_path)
                    begin
                        if (item.event_code == i2cms_pkg::EV_RX_SELECTED)
                        begin
                            if (rx_last_sel)
                            begin
                                result.ack_disable = 1'b1;
                                result.gen_stop    = 1'b1;
                            end
                        end
                        else if (item.event_code != i2cms_pkg::EV_RX_DONE)
                        begin
                            err = 1'b1;
                        end
                        else if (rx_more)
                        begin
                            result.byte_kind   = i2cms_pkg::BK_RECV;
                            result.out_byte    = item.rx_data;
                            result.rx_position = rpos_reg;
                            rpos_next          = rpos_inc;
                            if (rx_last_after)
                            begin
                                result.ack_disable = 1'b1;
                                result.gen_stop    = 1'b1;
                            end
                            else if (rx_end_after)
                            begin
                                result.irq_off = i2cms_pkg::IRQ_BOTH;
                                done_next      = 1'b1;
                                cnt_next       = '0;
                            end
                        end
                    end

                    // Unexpected event: stop the bus and drop the payload
                    if (err)
                    begin
                        result.irq_off  = i2cms_pkg::IRQ_BOTH;
                        result.gen_stop = 1'b1;
                        result.status   = i2cms_pkg::ST_RECOVERED;
                        cnt_next        = '0;
                    end
                end
            end
            default:
            begin
                // unused command code: no action
            end
        endcase

        result.complete = done_next;
    end

    // Store access: append on load, prefetch the entry the next send would use
    assign wr_en   = step && (item.command == i2cms_pkg::CMD_LOAD) && (cnt_reg < DEPTH_C);
    assign wr_addr = cnt_reg[IDX_W-1:0];
    assign wr_data = item.tx_byte;
    assign rd_full = (step ? sp_next : sp_reg) - SP_W'(step ? pcnt_next : pcnt_reg);
    assign rd_en   = (rd_full < DEPTH_S);
    assign rd_addr = rd_full[IDX_W-1:0];

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= '0;
            target_reg <= '0;
            cnt_reg    <= '0;
            prefix_reg <= '0;
            pcnt_reg   <= '0;
            sp_reg     <= '0;
            rlen_reg   <= '0;
            rpos_reg   <= '0;
            done_reg   <= 1'b1;
        end
        else if (step)
        begin
            kind_reg   <= kind_next;
            target_reg <= target_next;
            cnt_reg    <= cnt_next;
            prefix_reg <= prefix_next;
            pcnt_reg   <= pcnt_next;
            sp_reg     <= sp_next;
            rlen_reg   <= rlen_next;
            rpos_reg   <= rpos_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_transfer_sequencer.sv
// A result item passes through the input register and then the result register; a stall
// on the result side holds it in the input register. Throughput: one item per cycle while
// the result side is not stalled; the whole state update is logic between the input and
// result registers, and the payload store is read ahead of use. Reset: transfer state
// cleared, complete flag set, store contents undefined until loaded (no clearing pass).
`default_nettype none

module i2c_master_transfer_sequencer #(
    parameter int unsigned TX_DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire i2cms_pkg::in_item_t  cmd_item,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output i2cms_pkg::out_item_t      res_item
);

    localparam int unsigned IDX_W = $clog2(TX_DEPTH);

    logic                 in_valid_reg;
    i2cms_pkg::in_item_t  in_item_reg;
    logic                 res_valid_reg;
    i2cms_pkg::out_item_t res_item_reg;
    logic                 move;
    i2cms_pkg::out_item_t result;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [7:0]           rd_data;

    // Item moves from the input register to the result register
    assign move      = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || move;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            in_item_reg <= cmd_item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            res_item_reg <= result;
        end
    end

    i2cms_core #(
        .TX_DEPTH (TX_DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .item    (in_item_reg),
        .rd_data (rd_data),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr)
    );

    i2cms_store #(
        .TX_DEPTH (TX_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A held input item stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !move |=> in_valid_reg)
        else $error("input item lost while result stalled");

    // An accepted start on a free bus issues a start condition unless the store is overfull
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        move && (in_item_reg.command == i2cms_pkg::CMD_START) && !in_item_reg.bus_busy
        |=> res_valid_reg && ((res_item_reg.status == i2cms_pkg::ST_TOO_LONG)
            || (res_item_reg.gen_start && !res_item_reg.complete)))
        else $error("accepted start did not issue a start condition");

    // Error recovery always stops the bus with both interrupts off
    a_recover: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_item_reg.status == i2cms_pkg::ST_RECOVERED)
        |-> res_item_reg.gen_stop && (res_item_reg.irq_off == i2cms_pkg::IRQ_BOTH)
            && !res_item_reg.complete)
        else $error("error recovery without stop and interrupt disable");

endmodule

`default_nettype wire
